@@ sv/rcia_pkg.sv @@
`default_nettype none
package rcia_pkg;

   localparam int ID_W    = 15;
   localparam int OP_W    = 3;
   localparam int COUNT_W = 8;

   localparam logic [COUNT_W-1:0] COUNT_ZERO = 8'd0;
   localparam logic [COUNT_W-1:0] COUNT_ONE  = 8'd1;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'hFF;

   // counts are stored sixteen to a memory row
   localparam int ROW_ENTRIES = 16;
   localparam int ROW_SEL_W   = $clog2(ROW_ENTRIES);

   localparam int              NUM_IDS_DEFAULT = 1024;
   localparam logic [ID_W-1:0] ID_BASE_RESET   = 15'd1;

   typedef logic [ROW_ENTRIES-1:0][COUNT_W-1:0] row_type;

   typedef enum logic [OP_W-1:0] {
      OP_NEW_PROCESS = 3'd0,
      OP_JOIN        = 3'd1,
      OP_NEW_THREAD  = 3'd2,
      OP_RELEASE     = 3'd3,
      OP_DETACH      = 3'd4,
      OP_QUERY       = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_READ,
      ST_MODIFY,
      ST_RESPOND
   } state_type;

   function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] c);
      count_inc = (c == COUNT_MAX) ? c : c + COUNT_ONE;
   endfunction

   function automatic logic [COUNT_W-1:0] count_dec(input logic [COUNT_W-1:0] c);
      count_dec = (c == COUNT_ZERO) ? c : c - COUNT_ONE;
   endfunction

endpackage
`default_nettype wire

@@ sv/rcia_req_if.sv @@
`default_nettype none
interface rcia_req_if;
   logic                      valid;
   logic                      ready;
   logic [rcia_pkg::OP_W-1:0] operation;
   logic [rcia_pkg::ID_W-1:0] process_id;
   logic [rcia_pkg::ID_W-1:0] thread_id;

   modport source (output valid, output operation, output process_id, output thread_id,
                   input ready);
   modport sink   (input valid, input operation, input process_id, input thread_id,
                   output ready);
endinterface
`default_nettype wire

@@ sv/rcia_rsp_if.sv @@
`default_nettype none
interface rcia_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [rcia_pkg::ID_W-1:0] result_id;
   logic                      table_full;
   logic                      is_last;

   modport source (output valid, output result_id, output table_full, output is_last,
                   input ready);
   modport sink   (input valid, input result_id, input table_full, input is_last,
                   output ready);
endinterface
`default_nettype wire

@@ sv/rcia_count_mem.sv @@
`default_nettype none
module rcia_count_mem #(
   parameter int ROWS   = 64,
   parameter int ADDR_W = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire rcia_pkg::row_type wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output rcia_pkg::row_type      rd_data
);

   rcia_pkg::row_type mem [ROWS];
   rcia_pkg::row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ sv/refcounted_id_allocator.sv @@
`default_nettype none
// channel  | direction | payload                                  | handshake
// req_ch   | in        | operation, process_id, thread_id         | valid / ready
// rsp_ch   | out       | result_id, table_full, is_last           | valid / ready
// csr      | in        | csr_wr_data (id_base)                    | csr_wr_en
//
// after reset a clearing pass writes one row of sixteen counts per cycle over all
// ceil(NUM_IDS/16) rows (64 at 1024 slots) before the first request is taken
// release lowers the thread count, then the process count, where each slot is named
// new process takes the lowest free slot, scanning the rows from the first
// new thread reads the process count and scans for a free slot only when it is not one
// ready only in idle; a result waiting in the output register holds the next in respond
module refcounted_id_allocator #(
   parameter int NUM_IDS = rcia_pkg::NUM_IDS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [rcia_pkg::ID_W-1:0] csr_wr_data,
   rcia_req_if.sink                       req_ch,
   rcia_rsp_if.source                     rsp_ch
);

   localparam int ID_W      = rcia_pkg::ID_W;
   localparam int COUNT_W   = rcia_pkg::COUNT_W;
   localparam int ROW_SEL_W = rcia_pkg::ROW_SEL_W;
   localparam int ROWS      = (NUM_IDS + rcia_pkg::ROW_ENTRIES - 1) / rcia_pkg::ROW_ENTRIES;
   localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SLOT_W    = ROW_AW + ROW_SEL_W;
   localparam logic [ROW_AW-1:0] LAST_ROW  = ROW_AW'(ROWS - 1);
   localparam logic [ID_W:0]     ID_LIMIT  = (ID_W + 1)'(NUM_IDS);
   localparam logic [SLOT_W:0]   SLOT_LIMIT = (SLOT_W + 1)'(NUM_IDS);

   rcia_pkg::state_type state_ff, state_in;

   logic [ID_W-1:0]                  base_ff;
   logic [rcia_pkg::OP_W-1:0]        op_ff;
   logic [ID_W-1:0]                  pid_ff, tid_ff;
   logic [SLOT_W-1:0]                ps_ff, ts_ff;
   logic                             p_ok_ff, t_ok_ff;
   logic                             phase_ff, phase_in;
   logic [SLOT_W-1:0]                tgt_ff, tgt_in;
   logic [SLOT_W-1:0]                fs_ff, fs_in;
   logic [ROW_AW-1:0]                row_cnt_ff, row_cnt_in;
   logic                             scan_chk_ff, scan_chk_in;
   logic [ROW_AW-1:0]                rd_row_ff;
   logic [ID_W-1:0]                  res_ff, res_in;
   logic                             full_ff, full_in;
   logic                             last_ff, last_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]                  rsp_id_ff;
   logic                             rsp_full_ff, rsp_last_ff;

   logic                             accept;
   logic                             rsp_load;
   logic [ID_W-1:0]                  p_diff, t_diff;
   logic                             p_ok, t_ok;

   logic                             mem_wr_en;
   logic [ROW_AW-1:0]                mem_wr_addr, mem_rd_addr;
   rcia_pkg::row_type                mem_wr_data, mem_rd_data;

   logic [COUNT_W-1:0]               old_cnt, new_cnt;
   logic                             old_is_one;
   logic                             p_need;
   logic [rcia_pkg::ROW_ENTRIES-1:0] free_vec;
   logic                             free_found;
   logic [ROW_SEL_W-1:0]             free_idx;
   logic [SLOT_W-1:0]                free_slot;

   function automatic logic [ID_W-1:0] ident_of(input logic [ID_W-1:0] base,
                                                input logic [SLOT_W-1:0] slot);
      ident_of = base + ID_W'(slot);
   endfunction

   // slot decode of the incoming identifiers
   assign p_diff = req_ch.process_id - base_ff;
   assign t_diff = req_ch.thread_id - base_ff;
   assign p_ok   = (req_ch.process_id >= base_ff) && ({1'b0, p_diff} < ID_LIMIT);
   assign t_ok   = (req_ch.thread_id >= base_ff) && ({1'b0, t_diff} < ID_LIMIT);

   assign req_ch.ready = (state_ff == rcia_pkg::ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign rsp_load     = (state_ff == rcia_pkg::ST_RESPOND) && (!rsp_valid_ff || rsp_ch.ready);

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.result_id  = rsp_id_ff;
   assign rsp_ch.table_full = rsp_full_ff;
   assign rsp_ch.is_last    = rsp_last_ff;

   assign old_cnt    = mem_rd_data[tgt_ff[ROW_SEL_W-1:0]];
   assign old_is_one = (old_cnt == rcia_pkg::COUNT_ONE);
   assign p_need     = p_ok_ff && !(t_ok_ff && (ts_ff == ps_ff));

   always_comb begin
      unique case (op_ff)
         rcia_pkg::OP_JOIN:       new_cnt = rcia_pkg::count_inc(old_cnt);
         rcia_pkg::OP_NEW_THREAD: new_cnt = phase_ff ? rcia_pkg::count_inc(old_cnt) : old_cnt;
         rcia_pkg::OP_RELEASE:    new_cnt = rcia_pkg::count_dec(old_cnt);
         rcia_pkg::OP_DETACH:     new_cnt = old_is_one ? old_cnt : rcia_pkg::count_dec(old_cnt);
         default:                 new_cnt = old_cnt;
      endcase
   end

   // lowest free slot in the row just read, entries past the table excluded
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int e = rcia_pkg::ROW_ENTRIES - 1; e >= 0; e--) begin
         free_vec[e] = (mem_rd_data[e] == rcia_pkg::COUNT_ZERO) &&
                       ({1'b0, rd_row_ff, ROW_SEL_W'(e)} < SLOT_LIMIT);
         if (free_vec[e]) begin
            free_found = 1'b1;
            free_idx   = ROW_SEL_W'(e);
         end
      end
   end

   assign free_slot = {rd_row_ff, free_idx};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rcia_pkg::ST_CLEAR: begin
            if (row_cnt_ff == LAST_ROW) state_in = rcia_pkg::ST_IDLE;
         end
         rcia_pkg::ST_IDLE: begin
            if (accept) state_in = rcia_pkg::ST_START;
         end
         rcia_pkg::ST_START: begin
            unique case (op_ff)
               rcia_pkg::OP_NEW_PROCESS: state_in = rcia_pkg::ST_SCAN;
               rcia_pkg::OP_RELEASE:
                  state_in = (t_ok_ff || p_need) ? rcia_pkg::ST_READ : rcia_pkg::ST_RESPOND;
               rcia_pkg::OP_JOIN, rcia_pkg::OP_NEW_THREAD, rcia_pkg::OP_DETACH,
               rcia_pkg::OP_QUERY:
                  state_in = p_ok_ff ? rcia_pkg::ST_READ : rcia_pkg::ST_RESPOND;
               default: state_in = rcia_pkg::ST_RESPOND;
            endcase
         end
         rcia_pkg::ST_SCAN: begin
            if (scan_chk_ff && free_found) begin
               state_in = (op_ff == rcia_pkg::OP_NEW_THREAD) ? rcia_pkg::ST_READ
                                                             : rcia_pkg::ST_RESPOND;
            end else if (scan_chk_ff && (rd_row_ff == LAST_ROW)) begin
               state_in = rcia_pkg::ST_RESPOND;
            end
         end
         rcia_pkg::ST_READ: state_in = rcia_pkg::ST_MODIFY;
         rcia_pkg::ST_MODIFY: begin
            state_in = rcia_pkg::ST_RESPOND;
            if ((op_ff == rcia_pkg::OP_NEW_THREAD) && !phase_ff && !old_is_one) begin
               state_in = rcia_pkg::ST_SCAN;
            end else if ((op_ff == rcia_pkg::OP_RELEASE) && !phase_ff && p_need) begin
               state_in = rcia_pkg::ST_READ;
            end
         end
         rcia_pkg::ST_RESPOND: begin
            if (rsp_load) state_in = rcia_pkg::ST_IDLE;
         end
         default: state_in = rcia_pkg::ST_CLEAR;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      phase_in     = phase_ff;
      tgt_in       = tgt_ff;
      fs_in        = fs_ff;
      row_cnt_in   = row_cnt_ff;
      scan_chk_in  = scan_chk_ff;
      res_in       = res_ff;
      full_in      = full_ff;
      last_in      = last_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = tgt_ff[SLOT_W-1:ROW_SEL_W];
      mem_wr_data  = mem_rd_data;
      mem_rd_addr  = tgt_ff[SLOT_W-1:ROW_SEL_W];
      rsp_valid_in = (rsp_valid_ff && !rsp_ch.ready) || rsp_load;

      unique case (state_ff)
         rcia_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = row_cnt_ff;
            mem_wr_data = '0;
            row_cnt_in  = row_cnt_ff + ROW_AW'(1);
         end
         rcia_pkg::ST_IDLE: begin
            row_cnt_in  = '0;
            scan_chk_in = 1'b0;
         end
         rcia_pkg::ST_START: begin
            res_in   = '0;
            full_in  = 1'b0;
            last_in  = 1'b0;
            phase_in = 1'b0;
            tgt_in   = ps_ff;
            if ((op_ff == rcia_pkg::OP_RELEASE) && t_ok_ff) begin
               tgt_in = ts_ff;
            end else if (op_ff == rcia_pkg::OP_RELEASE) begin
               phase_in = 1'b1;
            end
         end
         rcia_pkg::ST_SCAN: begin
            mem_rd_addr = row_cnt_ff;
            scan_chk_in = 1'b1;
            if (row_cnt_ff != LAST_ROW) row_cnt_in = row_cnt_ff + ROW_AW'(1);
            if (scan_chk_ff && free_found) begin
               mem_wr_en             = 1'b1;
               mem_wr_addr           = rd_row_ff;
               mem_wr_data[free_idx] = rcia_pkg::COUNT_ONE;
               fs_in                 = free_slot;
               tgt_in                = ps_ff;
               phase_in              = 1'b1;
               if (op_ff == rcia_pkg::OP_NEW_PROCESS) res_in = ident_of(base_ff, free_slot);
            end else if (scan_chk_ff && (rd_row_ff == LAST_ROW)) begin
               full_in = 1'b1;
            end
         end
         rcia_pkg::ST_READ: begin
         end
         rcia_pkg::ST_MODIFY: begin
            mem_wr_en                          = 1'b1;
            mem_wr_data[tgt_ff[ROW_SEL_W-1:0]] = new_cnt;
            row_cnt_in                         = '0;
            scan_chk_in                        = 1'b0;
            unique case (op_ff)
               rcia_pkg::OP_JOIN:   res_in = pid_ff;
               rcia_pkg::OP_DETACH: res_in = tid_ff;
               rcia_pkg::OP_QUERY:  last_in = old_is_one;
               rcia_pkg::OP_NEW_THREAD: begin
                  if (phase_ff)        res_in = ident_of(base_ff, fs_ff);
                  else if (old_is_one) res_in = pid_ff;
               end
               rcia_pkg::OP_RELEASE: begin
                  if (!phase_ff) begin
                     tgt_in   = ps_ff;
                     phase_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         rcia_pkg::ST_RESPOND: begin
         end
         default: begin
         end
      endcase
   end

   rcia_count_mem #(
      .ROWS   (ROWS),
      .ADDR_W (ROW_AW)
   ) u_count_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcia_pkg::ST_CLEAR;
         base_ff      <= rcia_pkg::ID_BASE_RESET;
         row_cnt_ff   <= '0;
         scan_chk_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_cnt_ff   <= row_cnt_in;
         scan_chk_ff  <= scan_chk_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) base_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff    <= tgt_in;
      fs_ff     <= fs_in;
      res_ff    <= res_in;
      full_ff   <= full_in;
      last_ff   <= last_in;
      rd_row_ff <= mem_rd_addr;
      if (accept) begin
         op_ff   <= req_ch.operation;
         pid_ff  <= req_ch.process_id;
         tid_ff  <= req_ch.thread_id;
         ps_ff   <= p_diff[SLOT_W-1:0];
         ts_ff   <= t_diff[SLOT_W-1:0];
         p_ok_ff <= p_ok;
         t_ok_ff <= t_ok;
      end
      if (rsp_load) begin
         rsp_id_ff   <= res_ff;
         rsp_full_ff <= full_ff;
         rsp_last_ff <= last_ff;
      end
   end

endmodule
`default_nettype wire
